// ----- rtl/olvr_pkg.sv -----
package olvr_pkg;

	localparam int DEPTH_DEF      = 16;
	localparam int DATA_WIDTH_DEF = 32;
	localparam int OP_W           = 3;
	localparam int VAL_W          = 32;
	localparam int CNT_OUT_W      = 5;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND       = 3'd0,
		OP_PREPEND      = 3'd1,
		OP_REMOVE_MATCH = 3'd2,
		OP_REMOVE_FIRST = 3'd3,
		OP_REMOVE_LAST  = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_FROM_LEFT,
		CELL_FROM_RIGHT
	} cell_act_t;

	typedef struct packed {
		cell_act_t act;
	} cell_ctrl_t;

endpackage

// ----- rtl/olvr_req_if.sv -----
interface olvr_req_if import olvr_pkg::*;;
	logic             valid;
	logic             ready;
	logic [OP_W-1:0]  operation;
	logic [VAL_W-1:0] value;

	modport source (output valid, output operation, output value, input ready);
	modport sink (input valid, input operation, input value, output ready);
endinterface

// ----- rtl/olvr_rsp_if.sv -----
interface olvr_rsp_if import olvr_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic                 done_res;
	logic [CNT_OUT_W-1:0] count;
	logic [VAL_W-1:0]     head_value;
	logic [VAL_W-1:0]     tail_value;

	modport source (
		output valid, output done_res, output count, output head_value,
		output tail_value, input ready
	);
	modport sink (
		input valid, input done_res, input count, input head_value,
		input tail_value, output ready
	);
endinterface

// ----- rtl/olvr_cell.sv -----
module olvr_cell import olvr_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  cell_ctrl_t            ctrl,
	input  logic [DATA_WIDTH-1:0] load_data,
	input  logic [DATA_WIDTH-1:0] left_data,
	input  logic [DATA_WIDTH-1:0] right_data,
	output logic [DATA_WIDTH-1:0] data,
	output logic                  match
);

	logic [DATA_WIDTH-1:0] data_q;

	always_ff @(posedge clk) begin
		unique case (ctrl.act)
			CELL_LOAD:       data_q <= load_data;
			CELL_FROM_LEFT:  data_q <= left_data;
			CELL_FROM_RIGHT: data_q <= right_data;
			default:         data_q <= data_q;
		endcase
	end

	assign data  = data_q;
	assign match = (data_q == load_data);

endmodule

// ----- rtl/ordered_list_with_value_removal.sv -----
// A bounded list of up to DEPTH values held in a row of cells, packed from the head (cell 0)
// towards the tail. Each request transfer carries one operation: append, prepend, remove the
// first entry equal to a value, remove the head or remove the tail; each yields one response
// transfer with the done flag, the count and the head and tail values after the operation.
// The block works on one request at a time: after acceptance it compares every cell against
// the value in ST_MATCH, shifts the cells in ST_EXEC and forms the response in ST_FORM; the
// response is then offered in ST_SEND until taken, and a new request is accepted only after.
// Cell contents are not cleared by reset; only the count and the state are.
module ordered_list_with_value_removal import olvr_pkg::*; #(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input logic       clk,
	input logic       arst_n,
	olvr_req_if.sink  req,
	olvr_rsp_if.source rsp
);

	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MATCH,
		ST_EXEC,
		ST_FORM,
		ST_SEND
	} state_t;

	state_t                state_q;
	logic [CW-1:0]         count_q;
	op_t                   op_q;
	logic [DATA_WIDTH-1:0] value_q;
	logic [DEPTH-1:0]      hit_q;
	logic                  done_q;
	logic                  out_done_q;
	logic [CNT_OUT_W-1:0]  out_count_q;
	logic [VAL_W-1:0]      out_head_q;
	logic [VAL_W-1:0]      out_tail_q;

	logic [VAL_W+DATA_WIDTH-1:0] value_ext;
	logic [DATA_WIDTH-1:0]       value_fit;
	logic [DATA_WIDTH-1:0]       cell_data [DEPTH];
	logic [DEPTH-1:0]            cell_match;
	logic [DEPTH-1:0]            hit_pre;
	cell_ctrl_t                  cell_ctrl [DEPTH];
	logic                        full;
	logic                        empty;
	logic                        found;
	logic [DATA_WIDTH-1:0]       tail_sel;
	logic [DATA_WIDTH+VAL_W-1:0] head_ext;
	logic [DATA_WIDTH+VAL_W-1:0] tail_ext;
	logic [CW+CNT_OUT_W-1:0]     count_ext;

	assign value_ext = {{DATA_WIDTH{req.value[VAL_W-1]}}, req.value};
	assign value_fit = value_ext[DATA_WIDTH-1:0];

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);

	always_comb begin
		hit_pre[0] = hit_q[0];
		for (int i = 1; i < DEPTH; i++) begin
			hit_pre[i] = hit_pre[i-1] | hit_q[i];
		end
	end
	assign found = hit_pre[DEPTH-1];

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic [DATA_WIDTH-1:0] left_data;
		logic [DATA_WIDTH-1:0] right_data;

		if (g == 0) begin : g_first
			assign left_data = cell_data[0];
		end else begin : g_mid_left
			assign left_data = cell_data[g-1];
		end

		if (g == DEPTH - 1) begin : g_last
			assign right_data = cell_data[DEPTH-1];
		end else begin : g_mid_right
			assign right_data = cell_data[g+1];
		end

		always_comb begin
			cell_ctrl[g].act = CELL_HOLD;
			if (state_q == ST_EXEC) begin
				unique case (op_q)
					OP_APPEND: begin
						if (!full && count_q == CW'(g)) begin
							cell_ctrl[g].act = CELL_LOAD;
						end
					end
					OP_PREPEND: begin
						if (!full) begin
							cell_ctrl[g].act = (g == 0) ? CELL_LOAD : CELL_FROM_LEFT;
						end
					end
					OP_REMOVE_MATCH: begin
						if (hit_pre[g]) begin
							cell_ctrl[g].act = CELL_FROM_RIGHT;
						end
					end
					OP_REMOVE_FIRST: begin
						if (!empty) begin
							cell_ctrl[g].act = CELL_FROM_RIGHT;
						end
					end
					default: cell_ctrl[g].act = CELL_HOLD;
				endcase
			end
		end

		olvr_cell #(
			.DATA_WIDTH(DATA_WIDTH)
		) u_cell (
			.clk       (clk),
			.ctrl      (cell_ctrl[g]),
			.load_data (value_q),
			.left_data (left_data),
			.right_data(right_data),
			.data      (cell_data[g]),
			.match     (cell_match[g])
		);
	end

	always_comb begin
		tail_sel = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (count_q == CW'(i + 1)) begin
				tail_sel = tail_sel | cell_data[i];
			end
		end
	end

	assign head_ext  = {{VAL_W{1'b0}}, cell_data[0]};
	assign tail_ext  = {{VAL_W{1'b0}}, tail_sel};
	assign count_ext = {{CNT_OUT_W{1'b0}}, count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						state_q <= ST_MATCH;
					end
				end
				ST_MATCH: state_q <= ST_EXEC;
				ST_EXEC: begin
					state_q <= ST_FORM;
					unique case (op_q)
						OP_APPEND, OP_PREPEND: begin
							if (!full) begin
								count_q <= count_q + CW'(1);
							end
						end
						OP_REMOVE_MATCH: begin
							if (found) begin
								count_q <= count_q - CW'(1);
							end
						end
						OP_REMOVE_FIRST, OP_REMOVE_LAST: begin
							if (!empty) begin
								count_q <= count_q - CW'(1);
							end
						end
						default: count_q <= count_q;
					endcase
				end
				ST_FORM: state_q <= ST_SEND;
				ST_SEND: begin
					if (rsp.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req.valid) begin
			op_q    <= op_t'(req.operation);
			value_q <= value_fit;
		end
		if (state_q == ST_MATCH) begin
			for (int i = 0; i < DEPTH; i++) begin
				hit_q[i] <= cell_match[i] && (CW'(i) < count_q);
			end
		end
		if (state_q == ST_EXEC) begin
			unique case (op_q)
				OP_APPEND, OP_PREPEND:           done_q <= !full;
				OP_REMOVE_MATCH:                 done_q <= found;
				OP_REMOVE_FIRST, OP_REMOVE_LAST: done_q <= !empty;
				default:                         done_q <= 1'b0;
			endcase
		end
		if (state_q == ST_FORM) begin
			out_done_q  <= done_q;
			out_count_q <= count_ext[CNT_OUT_W-1:0];
			out_head_q  <= empty ? '0 : head_ext[VAL_W-1:0];
			out_tail_q  <= tail_ext[VAL_W-1:0];
		end
	end

	assign req.ready      = (state_q == ST_IDLE);
	assign rsp.valid      = (state_q == ST_SEND);
	assign rsp.done_res   = out_done_q;
	assign rsp.count      = out_count_q;
	assign rsp.head_value = out_head_q;
	assign rsp.tail_value = out_tail_q;

endmodule
